[rtl/core/xbf_pkg.sv]
// ----------------------------------------------------------------------------
// xbf_pkg
// shared types, constants and the crc-16 byte update for the xmodem framer
// ----------------------------------------------------------------------------
package xbf_pkg;

   localparam logic [7:0]  SOH      = 8'h01;
   localparam logic [7:0]  CTRL_Z   = 8'h1A;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // width of the repeat count carried with each output word
   localparam int REP_W = 7;

   // depth of the command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

   // one classified input word, as handed from front to back
   typedef struct packed {
      logic             is_eof;    // end mark with an open block
      logic             open_blk;  // data word that opens a new block
      logic             close_blk; // block closes after this command
      logic [7:0]       blk_num;   // number of the block this word belongs to
      logic [7:0]       data;      // file byte
      logic [REP_W-1:0] pad;       // ctrl-z run length on an end mark
   } cmd_type;

   // xmodem crc-16, msb first, one byte per call
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/core/xbf_front.sv]
// ----------------------------------------------------------------------------
// xbf_front
// accepts input words, tracks block fill and number, issues commands
// ----------------------------------------------------------------------------
module xbf_front
   import xbf_pkg::*;
#(
   parameter int CHUNK_BYTES = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    req_kind,
   input  logic [7:0] req_data,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   localparam int FILL_W = $clog2(CHUNK_BYTES);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        blk_ff, blk_in;
   logic [FILL_W:0]   fill_next;
   logic              accept;
   logic              open_blk;
   logic              close_data;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign open_blk   = (fill_ff == '0);
   assign fill_next  = {1'b0, fill_ff} + (FILL_W + 1)'(1);
   assign close_data = (fill_next == (FILL_W + 1)'(CHUNK_BYTES));

   always_comb begin
      fill_in          = fill_ff;
      blk_in           = blk_ff;
      q_push           = 1'b0;
      q_cmd.is_eof     = req_kind;
      q_cmd.open_blk   = 1'b0;
      q_cmd.close_blk  = 1'b0;
      q_cmd.blk_num    = blk_ff;
      q_cmd.data       = req_data;
      q_cmd.pad        = REP_W'((FILL_W + 1)'(CHUNK_BYTES) - {1'b0, fill_ff});
      if (accept) begin
         if (!req_kind) begin
            q_push          = 1'b1;
            q_cmd.open_blk  = open_blk;
            if (open_blk) begin
               blk_in = blk_ff + 8'd1;
            end
            q_cmd.blk_num   = blk_in;
            q_cmd.close_blk = close_data;
            fill_in         = close_data ? '0 : fill_next[FILL_W-1:0];
         end else begin
            // end mark on an empty block is dropped
            q_push          = !open_blk;
            q_cmd.close_blk = 1'b1;
            fill_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         blk_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         blk_ff  <= blk_in;
      end
   end

endmodule

[rtl/core/xbf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// xbf_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module xbf_cmd_fifo
   import xbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   cmd_type                mem_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CMDQ_PTR_W:0]    count_ff;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/core/xbf_back.sv]
// ----------------------------------------------------------------------------
// xbf_back
// sequences header, data, padding and trailer words into the output register
// ----------------------------------------------------------------------------
module xbf_back
   import xbf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             crc_mode,
   input  logic             q_empty,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_byte,
   output logic [REP_W-1:0] rsp_rep,
   output logic             rsp_last
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SOH    = 9'b000000010,
      ST_NUM    = 9'b000000100,
      ST_CPL    = 9'b000001000,
      ST_DATA   = 9'b000010000,
      ST_PAD    = 9'b000100000,
      ST_CRC_HI = 9'b001000000,
      ST_CRC_LO = 9'b010000000,
      ST_SUM    = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff;
   logic [REP_W-1:0] pad_cnt_ff, pad_cnt_in;
   logic [7:0]       sum_ff, sum_in;
   logic [15:0]      crc_ff, crc_in;
   logic             valid_ff;
   logic [7:0]       byte_ff;
   logic [REP_W-1:0] rep_ff;
   logic             last_ff;
   logic             out_free;
   logic             emit;
   logic [7:0]       emit_byte;
   logic [REP_W-1:0] emit_rep;
   logic             emit_last;
   state_type        trailer_st;

   assign out_free   = !valid_ff || rsp_tready;
   assign trailer_st = crc_mode ? ST_CRC_HI : ST_SUM;
   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in   = state_ff;
      pad_cnt_in = pad_cnt_ff;
      sum_in     = sum_ff;
      crc_in     = crc_ff;
      emit       = 1'b0;
      emit_byte  = cmd_ff.data;
      emit_rep   = REP_W'(1);
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pad_cnt_in = q_cmd.pad;
            if (!q_empty) begin
               if (q_cmd.is_eof) begin
                  state_in = ST_PAD;
               end else if (q_cmd.open_blk) begin
                  state_in = ST_SOH;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_SOH: begin
            emit_byte = SOH;
            if (out_free) begin
               emit     = 1'b1;
               sum_in   = '0;
               crc_in   = '0;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            emit_byte = cmd_ff.blk_num;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_CPL;
            end
         end
         ST_CPL: begin
            emit_byte = ~cmd_ff.blk_num;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               emit     = 1'b1;
               sum_in   = sum_ff + cmd_ff.data;
               crc_in   = crc16_feed(crc_ff, cmd_ff.data);
               state_in = cmd_ff.close_blk ? trailer_st : ST_IDLE;
            end
         end
         ST_PAD: begin
            emit_byte = CTRL_Z;
            emit_rep  = cmd_ff.pad;
            if (pad_cnt_ff != '0) begin
               // fold one pad byte per cycle into sum and crc
               sum_in     = sum_ff + CTRL_Z;
               crc_in     = crc16_feed(crc_ff, CTRL_Z);
               pad_cnt_in = pad_cnt_ff - 1'b1;
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = trailer_st;
            end
         end
         ST_CRC_HI: begin
            emit_byte = crc_ff[15:8];
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_CRC_LO;
            end
         end
         ST_CRC_LO: begin
            emit_byte = crc_ff[7:0];
            emit_last = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            emit_byte = sum_ff;
            emit_last = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      pad_cnt_ff <= pad_cnt_in;
      sum_ff     <= sum_in;
      crc_ff     <= crc_in;
      if (emit) begin
         byte_ff <= emit_byte;
         rep_ff  <= emit_rep;
         last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_rep    = rep_ff;
   assign rsp_last   = last_ff;

endmodule

[rtl/core/xmodem_block_framer.sv]
// ----------------------------------------------------------------------------
// xmodem_block_framer
// turns file bytes and end-of-file marks into xmodem blocks
// ----------------------------------------------------------------------------
// each input word is either a file byte (tuser 0) or an end-of-file mark
// (tuser 1). the first byte of a block is preceded by soh, the block number
// (from 1, wrapping at 8 bits) and its complement; data bytes pass through;
// a full block is closed by its trailer, an 8-bit sum or the crc-16 (poly
// 0x1021, init 0) high byte first, chosen by csr_wr_data at the last write
// (crc after reset). an end mark on a partly filled block gives one ctrl-z
// word whose repeat count is the number of pad bytes, then the trailer; an
// end mark on an empty block gives nothing. the output sequencer takes each
// command from the queue in its idle state; for a block-opening byte it then
// sends soh, number and complement before the byte, and after a block-closing
// byte it sends the trailer, the sum or the two crc bytes. for an end mark it
// folds the pad bytes (up to CHUNK_BYTES-1) into the sum and crc one per
// cycle, then sends the pad word and the trailer. output stalls can hold the
// sequencer. a two-entry command queue lets the input side run ahead of
// the output sequencer, and the output register holds each word while
// rsp_tready is low.
// ----------------------------------------------------------------------------
module xmodem_block_framer
   import xbf_pkg::*;
#(
   parameter int CHUNK_BYTES = 128   // data bytes per block, 16 to 128
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] kind
   // output words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] out_byte, [14:8] repeat_count, [15] zero
   output logic        rsp_tlast,    // frame_end
   // trailer select
   input  logic        csr_wr_en,
   input  logic        csr_wr_data   // crc_mode
);

   logic             crc_mode_ff;
   logic             q_push, q_full, q_pop, q_empty;
   cmd_type          push_cmd, pop_cmd;
   logic [7:0]       rsp_byte;
   logic [REP_W-1:0] rsp_rep;

   // trailer select register, crc after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         crc_mode_ff <= csr_wr_data;
      end
   end

   // front: classify words, keep fill count and block number
   xbf_front #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_data   (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // command queue decouples the two sides
   xbf_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // back: header, data, padding, sum and crc, trailer
   xbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .crc_mode   (crc_mode_ff),
      .q_empty    (q_empty),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_byte),
      .rsp_rep    (rsp_rep),
      .rsp_last   (rsp_tlast)
   );

   // pack output word, top bit filled with zero
   assign rsp_tdata = {1'b0, rsp_rep, rsp_byte};

endmodule

[rtl/core/xbf_checker.sv]
// ----------------------------------------------------------------------------
// xbf_checker
// port-level checks on the framer output stream
// ----------------------------------------------------------------------------
module xbf_checker
   import xbf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output word changed while stalled");

   // repeat count is never zero
   a_rep_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:8] != 7'd0)
      else $error("zero repeat count");

   // block-ending trailer byte is sent once
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[14:8] == 7'd1)
      else $error("repeated trailer byte");

   // only the ctrl-z padding run repeats
   a_run_is_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14:8] != 7'd1 |-> rsp_tdata[7:0] == CTRL_Z && !rsp_tlast)
      else $error("repeated word is not padding");

endmodule

bind xmodem_block_framer xbf_checker u_xbf_checker (.*);

[sim/xmodem_block_framer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmodem_block_framer_test
// self-checking bench for the xmodem block framer
// ----------------------------------------------------------------------------
// feeds file bytes and end-of-file marks through the stream input. a tracker
// class rebuilds the expected block stream: soh, block number and complement,
// data, ctrl-z padding run and the sum or crc-16 trailer. every output word is
// compared against it. short directed files come first, with a full block
// closed by its last byte. random files follow, with trailer mode changes
// between and inside blocks and now and then a full or oversize block.
// random stalls are applied on both sides.
// ----------------------------------------------------------------------------
module xmodem_block_framer_test
   import xbf_pkg::*;
();

   localparam int  CHUNK      = 128;         // data bytes per block
   localparam int  ITEMS      = 220;         // input words for the whole run
   localparam int  SETTLE     = CHUNK + 32;  // quiet stretch after the last word
   localparam int  IDLE_LIMIT = 4000;        // cycles without any handshake
   localparam int  MAX_SHOWN  = 10;          // mismatches printed in full
   localparam bit  KIND_DATA  = 1'b0;        // tuser: file byte
   localparam bit  KIND_EOF   = 1'b1;        // tuser: end of file

   // one expected output word
   typedef struct {
      logic [7:0] out_byte;
      logic [6:0] rep_count;
      logic       frame_end;
   } tx_word_type;

   // ------------------------------------------------------------------------
   // block tracker: predicts the framed stream and checks each output word
   // ------------------------------------------------------------------------
   class frame_tracker;
      bit          crc_mode;
      logic [7:0]  blk_num;
      logic [7:0]  fill;
      logic [7:0]  sum;
      logic [15:0] crc;
      tx_word_type pending_words[$];
      int          mismatches;
      int          words_checked;
      int          blocks_opened;
      int          pad_runs;

      function new();
         crc_mode = 1'b1;
         blk_num  = '0;
         fill     = '0;
         sum      = '0;
         crc      = '0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_SHOWN) $display("ERROR: %s", msg);
      endfunction

      function void push_word(logic [7:0] b, logic [6:0] n, logic e);
         tx_word_type w;
         w.out_byte  = b;
         w.rep_count = n;
         w.frame_end = e;
         pending_words.push_back(w);
      endfunction

      // crc-16 one bit at a time, data msb first
      function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
         logic fb;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function void add_byte(logic [7:0] b);
         sum = sum + b;
         crc = crc_byte(crc, b);
      endfunction

      function void close_block();
         if (crc_mode) begin
            push_word(crc[15:8], 7'd1, 1'b0);
            push_word(crc[7:0], 7'd1, 1'b1);
         end else begin
            push_word(sum, 7'd1, 1'b1);
         end
         fill = '0;
      endfunction

      // returns the number of words this input is expected to produce
      function int take_input(bit kind, logic [7:0] data);
         int start_size;
         int pad;
         start_size = pending_words.size();
         if (kind == KIND_DATA) begin
            if (fill == 0) begin
               blk_num = blk_num + 8'd1;
               sum     = '0;
               crc     = '0;
               blocks_opened++;
               push_word(SOH, 7'd1, 1'b0);
               push_word(blk_num, 7'd1, 1'b0);
               push_word(~blk_num, 7'd1, 1'b0);
            end
            add_byte(data);
            fill = fill + 8'd1;
            push_word(data, 7'd1, 1'b0);
            if (fill >= CHUNK) close_block();
         end else if (fill != 0) begin
            pad = CHUNK - fill;
            repeat (pad) add_byte(CTRL_Z);
            push_word(CTRL_Z, pad[6:0], 1'b0);
            pad_runs++;
            close_block();
         end
         return pending_words.size() - start_size;
      endfunction

      function void check_word(logic [7:0] b, logic [6:0] n, logic e);
         tx_word_type w;
         words_checked++;
         if (pending_words.size() == 0) begin
            flag($sformatf("unexpected word byte=%02h count=%0d last=%0b", b, n, e));
            return;
         end
         w = pending_words.pop_front();
         if (w.out_byte !== b || w.rep_count !== n || w.frame_end !== e)
            flag($sformatf({"word %0d: expected byte=%02h count=%0d last=%0b,",
                            " got byte=%02h count=%0d last=%0b"},
                           words_checked, w.out_byte, w.rep_count, w.frame_end,
                           b, n, e));
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals; the ones driven here are known from time zero
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;    // [7:0] data_byte
   logic        req_tuser   = 1'b0;  // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [14:8] repeat_count, [15] zero
   logic        rsp_tlast;           // frame_end
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;  // crc_mode

   frame_tracker sb;
   int           src_calm;       // sender words left in a no-stall stretch
   int           sink_calm;      // receiver words left in a no-stall stretch
   int           effective_words;
   int           quiet_cycles;
   int           mid_switches;
   bit [1:0]     modes_written;

   xmodem_block_framer #(
      .CHUNK_BYTES (CHUNK)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // random stall length for one word, with occasional stretches
   // of back-to-back words
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 9);
   endfunction

   // ------------------------------------------------------------------------
   // input side: one word per call, entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_word(bit kind, logic [7:0] data);
      int gap;
      int produced;
      gap = draw_gap(src_calm);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      // word moves at the first rising edge with ready high
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      produced = sb.take_input(kind, data);
      if (kind == KIND_DATA || produced > 0) effective_words++;
      @(negedge clock);
   endtask

   // hold input until every predicted word is out, then idle a while
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // trailer select write, only while the block is quiet
   task automatic set_trailer_mode(bit m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.crc_mode = m;
      modes_written[m] = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // output side: random ready stalls, one word at a time
   // ------------------------------------------------------------------------
   initial begin : sink
      int gap;
      forever begin
         gap = draw_gap(sink_calm);
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // check every accepted output word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata[7:0], rsp_tdata[14:8], rsp_tlast);
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d words still expected",
                     IDLE_LIMIT, sb.pending());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int len;
      int pick;
      int switch_at;
      sb = new();

      // reset, released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // end mark with nothing open gives no word
      send_word(KIND_EOF, 8'h00);
      // crc trailer (reset mode), extreme bytes, long pad run
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'hFF);
      send_word(KIND_EOF, 8'hC3);
      // second end mark on the now empty block
      send_word(KIND_EOF, 8'h5A);

      // full block closed by its last byte, then a short block
      for (int i = 0; i < CHUNK + 2; i++) send_word(KIND_DATA, 8'(i * 7 + 3));
      send_word(KIND_EOF, 8'h00);

      // checksum trailer
      wait_for_quiet();
      set_trailer_mode(1'b0);
      send_word(KIND_DATA, 8'hA5);
      send_word(KIND_DATA, 8'h5A);
      send_word(KIND_DATA, 8'h80);
      send_word(KIND_EOF, 8'hFF);

      // block opened under checksum, closed under crc
      send_word(KIND_DATA, 8'h12);
      wait_for_quiet();
      set_trailer_mode(1'b1);
      mid_switches++;
      send_word(KIND_DATA, 8'h34);
      send_word(KIND_EOF, 8'h01);

      // block opened under crc, closed under checksum
      send_word(KIND_DATA, 8'h7F);
      wait_for_quiet();
      set_trailer_mode(1'b0);
      mid_switches++;
      send_word(KIND_DATA, 8'hFE);
      send_word(KIND_EOF, 8'h00);

      wait_for_quiet();
      set_trailer_mode(1'b1);

      // random files until the word budget is used up
      while (effective_words < ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            wait_for_quiet();
            set_trailer_mode(1'($urandom_range(0, 1)));
         end
         pick = $urandom_range(0, 19);
         if (pick < 12)       len = $urandom_range(1, 3);
         else if (pick < 16)  len = $urandom_range(4, 40);
         else if (pick == 16) len = CHUNK;                            // exactly one block
         else if (pick == 17) len = $urandom_range(CHUNK - 3, CHUNK + 5);
         else if (pick == 18) len = 0;                                // stray end mark
         else                 len = $urandom_range(5, 60);            // mode flip inside
         // keep the total close to the budget
         if (len > ITEMS + 8 - effective_words) len = $urandom_range(1, 3);
         switch_at = (pick == 19 && len > 1) ? $urandom_range(1, len - 1) : -1;
         for (int i = 0; i < len; i++) begin
            if (i == switch_at) begin
               wait_for_quiet();
               set_trailer_mode(~sb.crc_mode);
               mid_switches++;
            end
            send_word(KIND_DATA, 8'($urandom_range(0, 255)));
         end
         // now and then the file runs on into the next one without an end mark
         if ($urandom_range(0, 9) != 0) send_word(KIND_EOF, 8'($urandom_range(0, 255)));
      end

      // drain: everything out, then a quiet stretch for stray words
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("run covered %0d input words, %0d output words, %0d blocks, %0d pad runs",
               effective_words, sb.words_checked, sb.blocks_opened, sb.pad_runs);
      $display("trailer modes used: checksum %0b, crc %0b; %0d changes inside a block",
               modes_written[0], modes_written[1], mid_switches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/xbf_pkg.sv
rtl/core/xbf_front.sv
rtl/core/xbf_cmd_fifo.sv
rtl/core/xbf_back.sv
rtl/core/xmodem_block_framer.sv
rtl/core/xbf_checker.sv
sim/xmodem_block_framer_test.sv
